@@ rtl/fir14_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir14_pkg
// Shared widths, codes, state and control types of the four-output FIR filter.
// ----------------------------------------------------------------------------
package fir14_pkg;

  localparam int DATA_W       = 16;
  localparam int IDX_W        = 6;
  localparam int CH_W         = 2;
  localparam int NUM_CH       = 4;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int TAPS_DEFAULT = 64;
  localparam int FRAC_W       = 15;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic load;
    logic issue;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic tap_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/fir14_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir14 channel interfaces
// Valid/ready channels for command words in and filtered words out.
// ----------------------------------------------------------------------------
interface fir14_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     cmd;
  logic signed [fir14_pkg::DATA_W-1:0]      sample;
  logic        [fir14_pkg::CH_W-1:0]        coef_channel;
  logic        [fir14_pkg::IDX_W-1:0]       coef_index;
  logic signed [fir14_pkg::DATA_W-1:0]      coef_value;

  modport source(output valid, cmd, sample, coef_channel, coef_index, coef_value,
                 input ready);
  modport sink(input valid, cmd, sample, coef_channel, coef_index, coef_value,
               output ready);
endinterface

interface fir14_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fir14_pkg::DATA_W-1:0] out_ch0;
  logic signed [fir14_pkg::DATA_W-1:0] out_ch1;
  logic signed [fir14_pkg::DATA_W-1:0] out_ch2;
  logic signed [fir14_pkg::DATA_W-1:0] out_ch3;

  modport source(output valid, out_ch0, out_ch1, out_ch2, out_ch3, input ready);
  modport sink(input valid, out_ch0, out_ch1, out_ch2, out_ch3, output ready);
endinterface
`default_nettype wire

@@ rtl/fir14_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir14_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fir14_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/fir14_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir14_ctrl
// Sequencer: clearing pass, command accept, tap sweep, drain and result hand-off.
// ----------------------------------------------------------------------------
module fir14_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_cmd,
  input  wire fir14_pkg::sts_t sts,
  output      logic            in_ready,
  output      fir14_pkg::ctl_t ctl
);

  fir14_pkg::state_t state;
  fir14_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fir14_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      fir14_pkg::ST_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.tap_last) begin
          state_next = fir14_pkg::ST_IDLE;
        end
      end
      fir14_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == fir14_pkg::CMD_LOAD) begin
            ctl.load = 1'b1;
          end else begin
            ctl.start  = 1'b1;
            state_next = fir14_pkg::ST_RUN;
          end
        end
      end
      fir14_pkg::ST_RUN: begin
        ctl.issue = 1'b1;
        if (sts.tap_last) begin
          state_next = fir14_pkg::ST_DRAIN_A;
        end
      end
      fir14_pkg::ST_DRAIN_A: begin
        state_next = fir14_pkg::ST_DRAIN_B;
      end
      fir14_pkg::ST_DRAIN_B: begin
        state_next = fir14_pkg::ST_FINISH;
      end
      fir14_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = fir14_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fir14_pkg::ST_CLEAR;
      end
    endcase
  end

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.clear, ctl.start, ctl.load, ctl.issue, ctl.finish}))
    else $error("More than one datapath command in a cycle.");

  a_finish_after_drain: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> $past(state == fir14_pkg::ST_DRAIN_B) || $past(state == fir14_pkg::ST_FINISH))
    else $error("Result taken before the accumulators drained.");

endmodule
`default_nettype wire

@@ rtl/fir14_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir14_datapath
// Delay line and coefficient RAMs, four MAC lanes, rounding and output register.
// ----------------------------------------------------------------------------
module fir14_datapath #(
  parameter int TAPS = fir14_pkg::TAPS_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire fir14_pkg::ctl_t                        ctl,
  output      fir14_pkg::sts_t                        sts,
  input  wire logic signed [fir14_pkg::DATA_W-1:0]    sample,
  input  wire logic        [fir14_pkg::CH_W-1:0]      coef_channel,
  input  wire logic        [fir14_pkg::IDX_W-1:0]     coef_index,
  input  wire logic signed [fir14_pkg::DATA_W-1:0]    coef_value,
  input  wire logic                                   out_ready,
  output      logic                                   out_valid,
  output      logic signed [fir14_pkg::DATA_W-1:0]    out_ch0,
  output      logic signed [fir14_pkg::DATA_W-1:0]    out_ch1,
  output      logic signed [fir14_pkg::DATA_W-1:0]    out_ch2,
  output      logic signed [fir14_pkg::DATA_W-1:0]    out_ch3
);

  localparam int AW     = $clog2(TAPS);
  localparam int ACC_W  = fir14_pkg::PROD_W + AW;
  localparam int DW     = fir14_pkg::DATA_W;
  localparam int NCH    = fir14_pkg::NUM_CH;
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
  localparam logic signed [ACC_W:0] HALF    = (ACC_W + 1)'(1 << (fir14_pkg::FRAC_W - 1));
  localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W + 1)'((1 << (DW - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_MIN = -(ACC_W + 1)'(1 << (DW - 1));

  logic [AW-1:0] ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] tap;
  logic          rd_vld;
  logic          prod_vld;

  logic [AW+fir14_pkg::IDX_W-1:0] idx_ext;
  logic [AW-1:0]                  coef_addr;
  logic                           idx_ok;

  logic              hist_we;
  logic [AW-1:0]     hist_waddr;
  logic [DW-1:0]     hist_wdata;
  logic signed [DW-1:0] hist_q;

  logic              coef_we [NCH];
  logic [AW-1:0]     coef_waddr;
  logic [DW-1:0]     coef_wdata;
  logic signed [DW-1:0] coef_q [NCH];

  logic signed [fir14_pkg::PROD_W-1:0] prod [NCH];
  logic signed [ACC_W-1:0]             acc  [NCH];
  logic signed [ACC_W:0]               biased  [NCH];
  logic signed [ACC_W:0]               shifted [NCH];
  logic signed [DW-1:0]                res     [NCH];
  logic signed [DW-1:0]                out_q   [NCH];

  assign idx_ext   = {{AW{1'b0}}, coef_index};
  assign coef_addr = idx_ext[AW-1:0];
  assign idx_ok    = 32'(coef_index) < 32'(TAPS);

  assign hist_we    = ctl.clear | ctl.start;
  assign hist_waddr = ctl.clear ? tap : ptr;
  assign hist_wdata = ctl.clear ? '0 : sample;
  assign coef_waddr = ctl.clear ? tap : coef_addr;
  assign coef_wdata = ctl.clear ? '0 : coef_value;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      coef_we[c] = ctl.clear | (ctl.load & idx_ok & (coef_channel == fir14_pkg::CH_W'(c)));
    end
  end

  fir14_ram #(.WIDTH(DW), .DEPTH(TAPS)) u_hist_ram (
    .clk  (clk),
    .we   (hist_we),
    .waddr(hist_waddr),
    .wdata(hist_wdata),
    .raddr(rd_ptr),
    .rdata(hist_q)
  );

  for (genvar g = 0; g < NCH; g++) begin : g_coef
    fir14_ram #(.WIDTH(DW), .DEPTH(TAPS)) u_coef_ram (
      .clk  (clk),
      .we   (coef_we[g]),
      .waddr(coef_waddr),
      .wdata(coef_wdata),
      .raddr(tap),
      .rdata(coef_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      rd_ptr    <= '0;
      tap       <= '0;
      rd_vld    <= 1'b0;
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld   <= ctl.issue;
      prod_vld <= rd_vld;
      if (ctl.start) begin
        tap    <= '0;
        rd_ptr <= ptr;
      end else if (ctl.clear || ctl.issue) begin
        tap <= (tap == LAST) ? '0 : tap + AW'(1);
      end
      if (ctl.issue) begin
        rd_ptr <= (rd_ptr == '0) ? LAST : rd_ptr - AW'(1);
      end
      if (ctl.finish) begin
        ptr       <= (ptr == LAST) ? '0 : ptr + AW'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      prod[c] <= coef_q[c] * hist_q;
      if (ctl.start) begin
        acc[c] <= '0;
      end else if (prod_vld) begin
        acc[c] <= acc[c] + ACC_W'(prod[c]);
      end
      if (ctl.finish) begin
        out_q[c] <= res[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      biased[c]  = {acc[c][ACC_W-1], acc[c]} + HALF;
      shifted[c] = biased[c] >>> fir14_pkg::FRAC_W;
      if (shifted[c] > SAT_MAX) begin
        res[c] = SAT_MAX[DW-1:0];
      end else if (shifted[c] < SAT_MIN) begin
        res[c] = SAT_MIN[DW-1:0];
      end else begin
        res[c] = shifted[c][DW-1:0];
      end
    end
  end

  assign out_ch0 = out_q[0];
  assign out_ch1 = out_q[1];
  assign out_ch2 = out_q[2];
  assign out_ch3 = out_q[3];

  assign sts.tap_last = (tap == LAST);
  assign sts.out_free = ~out_valid | out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> !out_valid || out_ready)
    else $error("Output word overwritten before it was taken.");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.finish))
    else $error("Output valid raised without a finished sum.");

  a_pipe_empty_on_start: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !rd_vld && !prod_vld)
    else $error("New sample started while products were still in flight.");

endmodule
`default_nettype wire

@@ rtl/fir_one_in_four_out_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_one_in_four_out_top
// One-input, four-output Q1.15 FIR filter with per-channel coefficient sets.
// ----------------------------------------------------------------------------
// A filter word sweeps the taps at one tap per cycle from the RAM read ports;
// the RAM and MAC pipeline then drains in ST_DRAIN_A and ST_DRAIN_B, and
// ST_FINISH, which waits while the previous result is stalled, rounds,
// saturates and registers the result and raises valid. The next word is
// accepted after that; a load word is written as it is accepted and the filter stays ready.
// After reset a clearing pass zeroes the delay line and all coefficients first.
// ----------------------------------------------------------------------------
module fir_one_in_four_out_top #(
  parameter int TAPS = fir14_pkg::TAPS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  fir14_in_if.sink     req,
  fir14_out_if.source  rsp
);

  fir14_pkg::ctl_t ctl;
  fir14_pkg::sts_t sts;
  logic            in_ready;

  assign req.ready = in_ready;

  fir14_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_cmd  (req.cmd),
    .sts     (sts),
    .in_ready(in_ready),
    .ctl     (ctl)
  );

  fir14_datapath #(.TAPS(TAPS)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .sample      (req.sample),
    .coef_channel(req.coef_channel),
    .coef_index  (req.coef_index),
    .coef_value  (req.coef_value),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_ch0     (rsp.out_ch0),
    .out_ch1     (rsp.out_ch1),
    .out_ch2     (rsp.out_ch2),
    .out_ch3     (rsp.out_ch3)
  );

endmodule
`default_nettype wire

@@ verif/fir_quad_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_quad_checker
// Watches the command and result channels of the four-output FIR filter. It
// keeps its own delay line and coefficient banks and works out the four
// rounded, saturated outputs of every accepted filter word. Each accepted
// result word is compared channel by channel with the oldest expected word.
// ----------------------------------------------------------------------------
module fir_quad_checker #(
  parameter int TAPS = fir14_pkg::TAPS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  fir14_in_if       req,
  fir14_out_if      rsp,
  output int        mismatches,
  output int        awaiting
);

  typedef logic signed [fir14_pkg::DATA_W-1:0] q15_t;
  typedef q15_t [fir14_pkg::NUM_CH-1:0] quad_t;

  q15_t  delay_line [TAPS];
  q15_t  coef_bank [fir14_pkg::NUM_CH][TAPS];
  int    write_slot;
  quad_t expected_outputs [$];

  function automatic q15_t round_saturate(input longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> fir14_pkg::FRAC_W;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[fir14_pkg::DATA_W-1:0];
  endfunction

  function automatic quad_t filter_word(input q15_t smp);
    quad_t  res;
    longint acc;
    int     pos;
    delay_line[write_slot] = smp;
    for (int ch = 0; ch < fir14_pkg::NUM_CH; ch++) begin
      acc = 0;
      pos = write_slot;
      for (int j = 0; j < TAPS; j++) begin
        acc += longint'(coef_bank[ch][j]) * longint'(delay_line[pos]);
        pos = (pos == 0) ? TAPS - 1 : pos - 1;
      end
      res[ch] = round_saturate(acc);
    end
    write_slot = (write_slot + 1 >= TAPS) ? 0 : write_slot + 1;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    quad_t want;
    quad_t got;
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        delay_line[i] = '0;
        for (int ch = 0; ch < fir14_pkg::NUM_CH; ch++) coef_bank[ch][i] = '0;
      end
      write_slot = 0;
      expected_outputs.delete();
      mismatches = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.out_ch3, rsp.out_ch2, rsp.out_ch1, rsp.out_ch0};
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("result word with none expected, out_ch0 %0d",
                                    $signed(got[0])));
        end else begin
          want = expected_outputs.pop_front();
          for (int ch = 0; ch < fir14_pkg::NUM_CH; ch++) begin
            if (got[ch] !== want[ch]) begin
              report_mismatch($sformatf("out_ch%0d expected %0d, got %0d", ch,
                                        $signed(want[ch]), $signed(got[ch])));
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.cmd == fir14_pkg::CMD_LOAD) begin
          if (int'(req.coef_index) < TAPS) begin
            coef_bank[req.coef_channel][req.coef_index] = req.coef_value;
          end
        end else begin
          expected_outputs.push_back(filter_word(req.sample));
        end
      end
    end
    awaiting = expected_outputs.size();
  end

endmodule

@@ verif/tb_fir_one_in_four_out_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_one_in_four_out_top
// Drives command words into the four-output FIR filter and takes its result
// words with random gaps and stalls. A short directed part covers rounding of
// halves, both saturation limits and field extremes; random phases follow
// with small, sparse and full-range coefficients. The checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_fir_one_in_four_out_top;

  typedef logic signed [fir14_pkg::DATA_W-1:0] q15_t;

  localparam int TAPS        = fir14_pkg::TAPS_DEFAULT;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 180;
  localparam int MAX_WAIT    = 13;

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   mismatches;
  int   awaiting;
  int   sent_words = 0;
  int   taken_results = 0;

  fir14_in_if  req_if ();
  fir14_out_if rsp_if ();

  fir_one_in_four_out_top #(.TAPS(TAPS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  fir_quad_checker #(.TAPS(TAPS)) quad_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_fir_one_in_four_out_top NOT OK");
    $finish;
  end

  function automatic int unsigned wait_draw(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic q15_t sample_draw();
    int r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0001;
      3: return 16'shffff;
      default: return r[fir14_pkg::DATA_W-1:0];
    endcase
  endfunction

  function automatic q15_t coef_draw(input int style);
    int r;
    r = $urandom;
    case (style)
      0: begin
        if ($urandom_range(0, 2) == 0) return '0;
        r = int'($urandom_range(0, 512)) - 256;
        return r[fir14_pkg::DATA_W-1:0];
      end
      1: begin
        case ($urandom_range(0, 5))
          0, 1: return '0;
          2: return 16'sh7fff;
          3: return 16'sh8000;
          default: return r[fir14_pkg::DATA_W-1:0];
        endcase
      end
      default: return r[fir14_pkg::DATA_W-1:0];
    endcase
  endfunction

  task automatic send_word(input logic c, input q15_t smp,
                           input logic [fir14_pkg::CH_W-1:0] chn,
                           input logic [fir14_pkg::IDX_W-1:0] idx, input q15_t val);
    int unsigned gap;
    gap = wait_draw(((sent_words / 48) % 4) == 2);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= c;
    req_if.sample       <= smp;
    req_if.coef_channel <= chn;
    req_if.coef_index   <= idx;
    req_if.coef_value   <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent_words++;
  endtask

  task automatic send_filter(input q15_t smp);
    int r;
    r = $urandom;
    send_word(fir14_pkg::CMD_FILTER, smp, r[1:0], r[7:2], r[31:16]);
  endtask

  task automatic send_load(input int chn, input int idx, input q15_t val);
    int r;
    r = $urandom;
    send_word(fir14_pkg::CMD_LOAD, r[15:0], chn[fir14_pkg::CH_W-1:0],
              idx[fir14_pkg::IDX_W-1:0], val);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  initial begin
    int unsigned stall;
    forever begin
      stall = wait_draw(((taken_results / 32) % 3) == 1);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      taken_results++;
    end
  end

  initial begin
    rst                 <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.cmd          <= fir14_pkg::CMD_FILTER;
    req_if.sample       <= '0;
    req_if.coef_channel <= '0;
    req_if.coef_index   <= '0;
    req_if.coef_value   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_filter(16'sh7fff);
    send_load(0, 0, 16'sh7fff);
    send_load(1, 0, 16'sh8000);
    send_load(2, 63, 16'sh8000);
    send_load(3, 0, 16'sh4000);
    send_filter(16'sh0001);
    send_filter(16'shffff);
    send_filter(16'sh8000);
    send_filter(16'sh7fff);
    send_load(0, 1, 16'sh7fff);
    send_filter(16'sh8000);
    send_filter(16'sh8000);
    send_load(3, 42, 16'sh5555);
    send_load(2, 21, 16'shaaaa);
    send_filter(16'sh0000);
    send_filter(16'sh2aaa);
    send_filter(16'shd555);
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      repeat (12) begin
        send_load($urandom_range(0, fir14_pkg::NUM_CH - 1), $urandom_range(0, TAPS - 1),
                  coef_draw(phase / 2));
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_load($urandom_range(0, fir14_pkg::NUM_CH - 1), $urandom_range(0, TAPS - 1),
                    coef_draw(phase / 2));
        end else begin
          send_filter(sample_draw());
        end
      end
      drain_results();
    end

    repeat (TAPS + 16) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("tb_fir_one_in_four_out_top OK");
    end else begin
      $display("tb_fir_one_in_four_out_top NOT OK");
    end
    $finish;
  end

endmodule
